>>> sv/mar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_pkg: shared constants for the middle axis reduction block
// Field widths, register indexes and mode codes.
// ----------------------------------------------------------------------------
package mar_pkg;

   localparam int DATA_W          = 32;
   localparam int MODE_W          = 2;
   localparam int DEPTH_W         = 16;
   localparam int COLS_W          = 11;
   localparam int GRP_W           = 16;
   localparam int MAX_COLUMNS_DEF = 1024;

   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int REG_IW  = 3;

   localparam logic [REG_IW-1:0] REG_MODE  = 3'd0;
   localparam logic [REG_IW-1:0] REG_DEPTH = 3'd1;
   localparam logic [REG_IW-1:0] REG_COLS  = 3'd2;
   localparam logic [REG_IW-1:0] REG_GRPS  = 3'd3;
   localparam logic [REG_IW-1:0] REG_BETA  = 3'd4;

   localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ASUM = 2'd2;

endpackage

>>> sv/mar_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_div: signed by unsigned restoring divider
// One quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mar_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mar_pkg::DATA_W-1:0]   dividend,
   input  logic        [mar_pkg::DEPTH_W-1:0]  divisor,
   output logic                                done,
   output logic signed [mar_pkg::DATA_W-1:0]   quotient
);
   import mar_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } state_type;

   state_type              state_ff;
   logic [DATA_W-1:0]      mag_ff;
   logic [DATA_W-1:0]      quo_ff;
   logic [DEPTH_W-1:0]     rem_ff;
   logic [DEPTH_W-1:0]     dvs_ff;
   logic                   neg_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   done_ff;
   logic signed [DATA_W-1:0] quotient_ff;

   logic [DEPTH_W:0]       trial_in;
   logic                   ge_in;
   logic [DEPTH_W:0]       diff_in;

   always_comb begin
      trial_in = {rem_ff, mag_ff[DATA_W-1]};
      ge_in    = trial_in >= {1'b0, dvs_ff};
      diff_in  = trial_in - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == ST_FIX);
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mag_ff   <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
                  neg_ff   <= dividend[DATA_W-1];
                  dvs_ff   <= divisor;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               rem_ff <= ge_in ? diff_in[DEPTH_W-1:0] : trial_in[DEPTH_W-1:0];
               quo_ff <= {quo_ff[DATA_W-2:0], ge_in};
               mag_ff <= {mag_ff[DATA_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DATA_W - 1)) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               quotient_ff <= neg_ff ? $signed(-quo_ff) : $signed(quo_ff);
               state_ff    <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;

   a_done_after_fix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == ST_FIX))
      else $error("divider done without sign fix step");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff != CNT_W'(DATA_W - 1)) |=> state_ff == ST_RUN)
      else $error("divider left run early");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == ST_IDLE) |=> state_ff == ST_RUN)
      else $error("divider did not start");

endmodule

>>> sv/middle_axis_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// middle_axis_reduction: column reduction of a groups x depth x columns tensor
// Per-column accumulators in one synchronous memory; sum, mean or abs sum.
//
//   channel  dir   fields
//   req_     in    tdata = element[31:0], prior_output[63:32]
//   rsp_     out   tdata = result_value[31:0], tlast = job_last
//   csr_     in    APB, mode/depth_count/column_count/group_count/beta
//
// Non-final-row item: accept with memory read, then accumulate/write.
// Final row: accept, accumulate, emit, with mean waiting for the 32-step
// divider. Reset clears positions and registers; accumulators are not
// cleared, the first depth row overwrites them. A stalled rsp_ holds the
// block in its emit step until the output register frees.
// ----------------------------------------------------------------------------
module middle_axis_reduction #(
   parameter int MAX_COLUMNS = mar_pkg::MAX_COLUMNS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*mar_pkg::DATA_W-1:0]  req_tdata,   // element, prior_output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mar_pkg::DATA_W-1:0]    rsp_tdata,   // result_value
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mar_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [mar_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [mar_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import mar_pkg::*;

   localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W  = ((COLS_W > COL_AW) ? COLS_W : COL_AW) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_EMIT
   } state_type;

   // configuration
   logic [MODE_W-1:0]  mode_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [GRP_W-1:0]   grps_ff;
   logic [DATA_W-1:0]  beta_ff;

   // positions
   logic [COL_AW-1:0]  col_pos_ff;
   logic [DEPTH_W-1:0] dep_pos_ff;
   logic [GRP_W-1:0]   grp_pos_ff;

   // item pipeline
   state_type          state_ff;
   logic [DATA_W-1:0]  term_ff;
   logic [DATA_W-1:0]  prior_ff;
   logic [COL_AW-1:0]  addr_ff;
   logic               first_ff;
   logic               dep_last_ff;
   logic               job_last_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   logic [DATA_W-1:0]  acc_ff;
   logic [DATA_W-1:0]  prod_ff;
   logic               div_start_ff;
   logic               rsp_tvalid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_tlast_ff;

   logic [DATA_W-1:0]  sums_mem [MAX_COLUMNS];

   logic [CNT_W-1:0]   cols_in;
   logic [DEPTH_W:0]   deps_in;
   logic [GRP_W:0]     grps_in;
   logic               col_last_in;
   logic               dep_last_in;
   logic               grp_last_in;
   logic               req_fire_in;
   logic               csr_wr_in;
   logic [REG_IW-1:0]  csr_idx_in;
   logic [DATA_W-1:0]  elem_in;
   logic [DATA_W-1:0]  term_in;
   logic [DATA_W-1:0]  acc_in;
   logic [DATA_W-1:0]  base_in;
   logic               out_free_in;
   logic               emit_in;
   logic               div_done;
   logic signed [DATA_W-1:0] div_quot;

   always_comb begin
      cols_in = (cols_ff == '0) ? CNT_W'(1) : CNT_W'(cols_ff);
      if (cols_in > CNT_W'(MAX_COLUMNS)) begin
         cols_in = CNT_W'(MAX_COLUMNS);
      end
      deps_in = (depth_ff == '0) ? (DEPTH_W+1)'(1) : {1'b0, depth_ff};
      grps_in = (grps_ff == '0) ? (GRP_W+1)'(1) : {1'b0, grps_ff};
      col_last_in = (CNT_W'(col_pos_ff) + CNT_W'(1)) >= cols_in;
      dep_last_in = ({1'b0, dep_pos_ff} + (DEPTH_W+1)'(1)) >= deps_in;
      grp_last_in = ({1'b0, grp_pos_ff} + (GRP_W+1)'(1)) >= grps_in;
      elem_in = req_tdata[DATA_W-1:0];
      term_in = (mode_ff == MODE_ASUM && elem_in[DATA_W-1]) ? (-elem_in) : elem_in;
      acc_in  = first_ff ? term_ff : rd_data_ff + term_ff;
      base_in = (mode_ff == MODE_MEAN) ? DATA_W'(div_quot) : acc_ff;
      out_free_in = !rsp_tvalid_ff || rsp_tready;
      emit_in     = (state_ff == ST_EMIT) && out_free_in;
      req_fire_in = req_tvalid && req_tready;
      csr_wr_in   = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_idx_in  = csr_paddr[CSR_AW-1:2];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx_in)
         REG_MODE:  csr_prdata = CSR_DW'(mode_ff);
         REG_DEPTH: csr_prdata = CSR_DW'(depth_ff);
         REG_COLS:  csr_prdata = CSR_DW'(cols_ff);
         REG_GRPS:  csr_prdata = CSR_DW'(grps_ff);
         REG_BETA:  csr_prdata = beta_ff;
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SUM;
         depth_ff <= DEPTH_W'(1);
         cols_ff  <= COLS_W'(1);
         grps_ff  <= GRP_W'(1);
         beta_ff  <= '0;
      end else if (csr_wr_in) begin
         case (csr_idx_in)
            REG_MODE:  mode_ff  <= csr_pwdata[MODE_W-1:0];
            REG_DEPTH: depth_ff <= csr_pwdata[DEPTH_W-1:0];
            REG_COLS:  cols_ff  <= csr_pwdata[COLS_W-1:0];
            REG_GRPS:  grps_ff  <= csr_pwdata[GRP_W-1:0];
            REG_BETA:  beta_ff  <= csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // accumulator memory
   always_ff @(posedge clock) begin
      if (req_fire_in) begin
         rd_data_ff <= sums_mem[col_pos_ff];
      end
      if (state_ff == ST_ACC) begin
         sums_mem[addr_ff] <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_pos_ff    <= '0;
         dep_pos_ff    <= '0;
         grp_pos_ff    <= '0;
         div_start_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         div_start_ff  <= (state_ff == ST_ACC) && dep_last_ff && (mode_ff == MODE_MEAN);
         rsp_tvalid_ff <= emit_in || (rsp_tvalid_ff && !rsp_tready);
         case (state_ff)
            ST_IDLE: begin
               if (req_fire_in) begin
                  term_ff     <= term_in;
                  prior_ff    <= req_tdata[2*DATA_W-1:DATA_W];
                  addr_ff     <= col_pos_ff;
                  first_ff    <= (dep_pos_ff == '0);
                  dep_last_ff <= dep_last_in;
                  job_last_ff <= col_last_in && grp_last_in;
                  if (col_last_in) begin
                     col_pos_ff <= '0;
                     if (dep_last_in) begin
                        dep_pos_ff <= '0;
                        grp_pos_ff <= grp_last_in ? '0 : grp_pos_ff + GRP_W'(1);
                     end else begin
                        dep_pos_ff <= dep_pos_ff + DEPTH_W'(1);
                     end
                  end else begin
                     col_pos_ff <= col_pos_ff + COL_AW'(1);
                  end
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               acc_ff  <= acc_in;
               prod_ff <= DATA_W'(beta_ff * prior_ff);
               if (!dep_last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (mode_ff == MODE_MEAN) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_in) begin
                  rsp_data_ff  <= base_in + prod_ff;
                  rsp_tlast_ff <= job_last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   mar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend ($signed(acc_ff)),
      .divisor  (deps_in[DEPTH_W-1:0]),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit step");

   a_accept_to_acc: assert property (@(posedge clock) disable iff (reset)
      req_fire_in |=> state_ff == ST_ACC)
      else $error("accepted transaction not accumulated");

   a_job_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire_in && col_last_in && dep_last_in && grp_last_in)
      |=> (col_pos_ff == '0 && dep_pos_ff == '0 && grp_pos_ff == '0))
      else $error("positions not cleared at end of job");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide step");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for middle_axis_reduction
// Streams tensor elements with prior outputs into the block, keeps its own
// copy of the column accumulators and positions, and checks each result
// transaction against the predicted column value and job end flag. Directed
// tests cover value extremes, every mode, zero and oversized counts and
// counts changed mid-job; random jobs then run under several stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import mar_pkg::*;

   localparam int MAX_COLS      = MAX_COLUMNS_DEF;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES  = 60;
   localparam int MAX_REPORTS   = 10;
   localparam int WIDE_ITEMS    = 64;

   localparam logic [MODE_W-1:0] MODE_ALT_SUM = 2'd3;
   localparam logic [DATA_W-1:0] MOST_NEG     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POS     = 32'h7fff_ffff;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              job_last;
   } column_result_t;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [2*DATA_W-1:0]  req_tdata   = '0;   // element, prior_output
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;          // result_value
   logic                 rsp_tlast;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr   = '0;
   logic [CSR_DW-1:0]    csr_pwdata  = '0;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   // predictor state
   logic [DATA_W-1:0]    acc_mem [MAX_COLS];
   int unsigned          pos_col   = 0;
   int unsigned          pos_depth = 0;
   int unsigned          pos_group = 0;
   int unsigned          written_cols = 0;   // accumulators 0..written_cols-1 hold data
   logic [MODE_W-1:0]    cfg_mode    = MODE_SUM;
   logic [DEPTH_W-1:0]   cfg_depth   = 1;
   logic [COLS_W-1:0]    cfg_columns = 1;
   logic [GRP_W-1:0]     cfg_groups  = 1;
   logic [DATA_W-1:0]    cfg_beta    = '0;

   column_result_t       column_results[$];

   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   int                   items_sent     = 0;
   int                   error_count    = 0;
   int                   cycle_count    = 0;

   middle_axis_reduction dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL middle_axis_reduction");
         $finish;
      end
   end

   task automatic flag_error(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch %s: expected %h, got %h (cycle %0d)", what, want, got,
                  cycle_count);
   endtask

   always @(posedge clock) begin : check_results
      column_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (column_results.size() == 0) begin
            flag_error("unexpected transaction", 'x, rsp_tdata);
         end else begin
            want = column_results.pop_front();
            if (rsp_tdata !== want.value)
               flag_error("result_value", want.value, rsp_tdata);
            if (rsp_tlast !== want.job_last)
               flag_error("job_last", want.job_last, rsp_tlast);
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic int unsigned clamp_count(input int unsigned c, input int unsigned cap);
      if (c == 0) return 1;
      if (c > cap) return cap;
      return c;
   endfunction

   // advances the predictor by one element; returns 1 when it ends a job
   function automatic logic reduce_step(input logic [DATA_W-1:0] elem,
                                        input logic [DATA_W-1:0] prior);
      int unsigned       cols, deps, grps;
      logic              col_last, dep_last, grp_last;
      logic [DATA_W-1:0] term, total, outv;
      int                signed_total;
      cols = clamp_count(cfg_columns, MAX_COLS);
      deps = clamp_count(cfg_depth, 65535);
      grps = clamp_count(cfg_groups, 65535);
      col_last = (pos_col + 1 >= cols);
      dep_last = (pos_depth + 1 >= deps);
      grp_last = (pos_group + 1 >= grps);
      term = (cfg_mode == MODE_ASUM && elem[DATA_W-1]) ? 32'd0 - elem : elem;
      total = (pos_depth == 0) ? term : acc_mem[pos_col % MAX_COLS] + term;
      acc_mem[pos_col % MAX_COLS] = total;
      if (pos_col % MAX_COLS + 1 > written_cols) written_cols = pos_col % MAX_COLS + 1;
      reduce_step = 1'b0;
      if (dep_last) begin
         if (cfg_mode == MODE_MEAN) begin
            signed_total = total;
            outv = signed_total / int'(deps);
         end else begin
            outv = total;
         end
         outv = outv + cfg_beta * prior;
         column_results.push_back('{value: outv, job_last: col_last && grp_last});
         reduce_step = col_last && grp_last;
      end
      if (col_last) begin
         pos_col = 0;
         if (dep_last) begin
            pos_depth = 0;
            pos_group = grp_last ? 0 : pos_group + 1;
         end else begin
            pos_depth++;
         end
      end else begin
         pos_col++;
      end
   endfunction

   task automatic send_element(input logic [DATA_W-1:0] elem, input logic [DATA_W-1:0] prior,
                               output logic job_end);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      job_end = reduce_step(elem, prior);
      req_tvalid <= 1'b1;
      req_tdata  <= {prior, elem};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (column_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MODE:  cfg_mode    = value[MODE_W-1:0];
         REG_DEPTH: cfg_depth   = value[DEPTH_W-1:0];
         REG_COLS:  cfg_columns = value[COLS_W-1:0];
         REG_GRPS:  cfg_groups  = value[GRP_W-1:0];
         REG_BETA:  cfg_beta    = value;
         default: ;
      endcase
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [MODE_W-1:0] m, input logic [DEPTH_W-1:0] d,
                            input logic [COLS_W-1:0] c, input logic [GRP_W-1:0] g,
                            input logic [DATA_W-1:0] b);
      wait_idle();
      csr_write(REG_MODE, m);
      csr_write(REG_DEPTH, d);
      csr_write(REG_COLS, c);
      csr_write(REG_GRPS, g);
      csr_write(REG_BETA, b);
      csr_release();
   endtask

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(9))
         0, 1, 2, 3: rand_word = $urandom();
         4, 5, 6: begin
            rand_word = $urandom_range(200);
            rand_word = rand_word - 32'd100;
         end
         7: rand_word = MOST_NEG;
         8: rand_word = MOST_POS;
         default: rand_word = $urandom_range(1) ? 32'hffff_ffff : 32'd0;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_beta();
      case ($urandom_range(9))
         0, 1, 2, 3: pick_beta = '0;
         4, 5: begin
            pick_beta = $urandom_range(10);
            pick_beta = pick_beta - 32'd5;
         end
         6, 7: pick_beta = $urandom();
         8: pick_beta = MOST_NEG;
         default: pick_beta = MOST_POS;
      endcase
   endfunction

   task automatic test_reset_defaults();
      logic done;
      send_element(MOST_POS, rand_word(), done);
      send_element(MOST_NEG, MOST_NEG, done);
   endtask

   task automatic test_zero_counts();
      logic done;
      configure(MODE_ALT_SUM, '0, '0, '0, 32'hffff_ffff);
      send_element(32'hffff_fff6, 32'd3, done);
      send_element(MOST_POS, MOST_NEG, done);
   endtask

   task automatic test_abs_sum();
      logic done;
      configure(MODE_ASUM, 2, 1, 2, MOST_POS);
      send_element(MOST_NEG, 32'd0, done);
      send_element(32'hffff_fffb, 32'd2, done);
      send_element(32'd7, MOST_POS, done);
      send_element(32'hffff_ffff, MOST_NEG, done);
   endtask

   task automatic test_mean();
      logic done;
      configure(MODE_MEAN, 3, 2, 1, MOST_NEG);
      send_element(32'hffff_fff9, rand_word(), done);
      send_element(MOST_POS, rand_word(), done);
      send_element(32'd0, rand_word(), done);
      send_element(32'd1, rand_word(), done);
      send_element(32'd0, 32'd1, done);
      send_element(32'd0, 32'hffff_ffff, done);
   endtask

   // counts shrink under a job in progress; only columns already written are reread
   task automatic test_count_change();
      logic done;
      configure(MODE_SUM, 16'hffff, 3, 16'hffff, 32'd1);
      repeat (5) send_element(rand_word(), rand_word(), done);
      wait_idle();
      csr_write(REG_DEPTH, 2);
      csr_write(REG_COLS, 2);
      csr_release();
      send_element(rand_word(), rand_word(), done);
      wait_idle();
      csr_write(REG_GRPS, 1);
      csr_release();
      repeat (4) send_element(rand_word(), rand_word(), done);
   endtask

   // oversized column count with a single depth row; every element yields a result
   task automatic test_column_limit();
      logic done;
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      configure(MODE_ASUM, 1, 11'h7ff, 1, pick_beta());
      repeat (WIDE_ITEMS) send_element(rand_word(), rand_word(), done);
   endtask

   task automatic random_job();
      logic [MODE_W-1:0]  m;
      logic [DEPTH_W-1:0] d;
      logic [COLS_W-1:0]  c;
      logic [GRP_W-1:0]   g;
      longint             job_len;
      int                 n, r;
      logic               done;
      m = MODE_W'($urandom_range(3));
      r = $urandom_range(99);
      if (r < 8) d = 0;
      else if (r < 86) d = DEPTH_W'($urandom_range(6, 1));
      else if (r < 98) d = DEPTH_W'($urandom_range(40, 7));
      else d = 16'hffff;
      r = $urandom_range(99);
      if (r < 8) c = 0;
      else if (r < 88) c = COLS_W'($urandom_range(10, 1));
      else if (r < 98) c = COLS_W'($urandom_range(64, 11));
      else c = 11'h7ff;
      // past the first row of a job, columns may not grow beyond those written
      if (pos_depth != 0 && clamp_count(c, MAX_COLS) > written_cols)
         c = COLS_W'(written_cols);
      r = $urandom_range(99);
      if (r < 10) g = 0;
      else if (r < 94) g = GRP_W'($urandom_range(4, 1));
      else if (r < 98) g = GRP_W'($urandom_range(8, 5));
      else g = 16'hffff;
      configure(m, d, c, g, pick_beta());
      job_len = longint'(clamp_count(d, 65535)) * clamp_count(c, MAX_COLS)
                * clamp_count(g, 65535);
      if (job_len > 240) n = $urandom_range(60, 1);
      else if ($urandom_range(99) < 15) n = $urandom_range(int'(job_len), 1);
      else n = int'(job_len);
      done = 1'b0;
      for (int i = 0; i < n && !done; i++) send_element(rand_word(), rand_word(), done);
   endtask

   task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
      int start;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start = items_sent;
      while (items_sent - start < n_items) random_job();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_zero_counts();
      test_abs_sum();
      test_mean();
      test_count_change();
      test_column_limit();
      test_random(0, 0, 150);
      test_random(77, 0, 150);
      test_random(0, 77, 150);
      test_random(16, 16, 150);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS middle_axis_reduction");
      end else begin
         $display("FAIL middle_axis_reduction");
      end
      $finish;
   end

endmodule
